// ===== hdl/cbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types, constants and fixed-point helpers for the cascaded balance
// PID core (signed Q16.16 values, unsigned Q8.16 gains).
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned GainW    = 24;
  localparam int unsigned LimW     = 18;
  localparam int unsigned TgtW     = 19;
  localparam int unsigned DtW      = 16;
  localparam int unsigned ProdW    = ValW + GainW + 1;
  localparam int unsigned ShiftW   = ProdW - FracW;
  localparam int unsigned InW      = 5 * ValW;
  localparam int unsigned OutW     = 216;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [ValW-1:0] ValMax   = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin   = {1'b1, {(ValW-1){1'b0}}};
  // half of the cart width, 0.375 m
  localparam logic signed [ValW-1:0] HalfCart = ValW'(3 << (FracW - 3));

  localparam logic signed [ValW-1:0] RstTargetPos = 32'sd163840;
  localparam logic [GainW-1:0]       RstKpAngle   = 24'd2293760;
  localparam logic [GainW-1:0]       RstKiAngle   = 24'd32768;
  localparam logic [GainW-1:0]       RstKdAngle   = 24'd655360;
  localparam logic [GainW-1:0]       RstKpPos     = 24'd1311;
  localparam logic [GainW-1:0]       RstKdPos     = 24'd6554;
  localparam logic [LimW-1:0]        RstMaxAngle  = 18'd3277;
  localparam logic [DtW-1:0]         RstTimeStep  = 16'd1092;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TARGET_POS = 3'd0,
    CFG_KP_ANGLE   = 3'd1,
    CFG_KI_ANGLE   = 3'd2,
    CFG_KD_ANGLE   = 3'd3,
    CFG_KP_POS     = 3'd4,
    CFG_KD_POS     = 3'd5,
    CFG_MAX_ANGLE  = 3'd6,
    CFG_TIME_STEP  = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_MUL_VEL,
    ST_TGT,
    ST_AERR,
    ST_MUL_DT,
    ST_MUL_KP,
    ST_MUL_KI,
    ST_MUL_KD,
    ST_SUM_PD,
    ST_SUM_I,
    ST_DONE
  } cbp_state_e;

  typedef enum logic [2:0] {
    MUL_POS_KP,
    MUL_VEL_KD,
    MUL_ERR_DT,
    MUL_ERR_KP,
    MUL_INT_KI,
    MUL_RATE_KD
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     wr_a;
    logic     wr_tgt;
    logic     wr_aerr;
    logic     wr_integ;
    logic     wr_p;
    logic     wr_i;
    logic     wr_pd;
    logic     wr_sum_i;
    logic     load_out;
  } cbp_cmd_t;

  typedef struct packed {
    logic out_free;
  } cbp_stat_t;

  function automatic logic signed [ValW-1:0] sat_add(logic signed [ValW-1:0] a,
                                                     logic signed [ValW-1:0] b);
    logic signed [ValW:0] s;
    s = {a[ValW-1], a} + {b[ValW-1], b};
    if (s[ValW] != s[ValW-1]) begin
      return s[ValW] ? ValMin : ValMax;
    end
    return s[ValW-1:0];
  endfunction

  function automatic logic signed [ValW-1:0] sat_sub(logic signed [ValW-1:0] a,
                                                     logic signed [ValW-1:0] b);
    logic signed [ValW:0] s;
    s = {a[ValW-1], a} - {b[ValW-1], b};
    if (s[ValW] != s[ValW-1]) begin
      return s[ValW] ? ValMin : ValMax;
    end
    return s[ValW-1:0];
  endfunction

  // floor shift by the fraction width, then saturate
  function automatic logic signed [ValW-1:0] mul_round(logic signed [ProdW-1:0] p);
    logic [ShiftW-1:0] q;
    q = p[ProdW-1:FracW];
    if ((&q[ShiftW-1:ValW-1]) || !(|q[ShiftW-1:ValW-1])) begin
      return q[ValW-1:0];
    end
    return q[ShiftW-1] ? ValMin : ValMax;
  endfunction

endpackage

// ===== hdl/cbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbp_ctrl
// Sequencer for one control tick: steps the shared multiplier through the
// outer and inner loop products and hands the result to the output register.
// ----------------------------------------------------------------------------
module cbp_ctrl
  import cbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cbp_stat_t stat_i,
  output cbp_cmd_t  cmd_o
);

  cbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_POS_KP;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_MUL_POS;
        end
      end
      ST_MUL_POS: begin
        cmd_o.mul_sel = MUL_POS_KP;
        state_d       = ST_MUL_VEL;
      end
      ST_MUL_VEL: begin
        cmd_o.mul_sel = MUL_VEL_KD;
        cmd_o.wr_a    = 1'b1;
        state_d       = ST_TGT;
      end
      ST_TGT: begin
        cmd_o.wr_tgt = 1'b1;
        state_d      = ST_AERR;
      end
      ST_AERR: begin
        cmd_o.wr_aerr = 1'b1;
        state_d       = ST_MUL_DT;
      end
      ST_MUL_DT: begin
        cmd_o.mul_sel = MUL_ERR_DT;
        state_d       = ST_MUL_KP;
      end
      ST_MUL_KP: begin
        cmd_o.mul_sel  = MUL_ERR_KP;
        cmd_o.wr_integ = 1'b1;
        state_d        = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        cmd_o.mul_sel = MUL_INT_KI;
        cmd_o.wr_p    = 1'b1;
        state_d       = ST_MUL_KD;
      end
      ST_MUL_KD: begin
        cmd_o.mul_sel = MUL_RATE_KD;
        cmd_o.wr_i    = 1'b1;
        state_d       = ST_SUM_PD;
      end
      ST_SUM_PD: begin
        cmd_o.wr_pd = 1'b1;
        state_d     = ST_SUM_I;
      end
      ST_SUM_I: begin
        cmd_o.wr_sum_i = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> stat_i.out_free)
    else $error("output loaded while previous word still pending");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MUL_POS))
    else $error("accepted word did not start a tick");

  a_done_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && stat_i.out_free) |=> (state_q == ST_IDLE))
    else $error("finished tick did not return to idle");

endmodule

// ===== hdl/cbp_dpath.sv =====
// ----------------------------------------------------------------------------
// cbp_dpath
// Configuration registers, working registers, one shared 32x24 multiplier
// with registered product, the error integral and the output register.
// ----------------------------------------------------------------------------
module cbp_dpath
  import cbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [InW-1:0]      in_data_i,
  input  cbp_cmd_t            cmd_i,
  output cbp_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutW-1:0]     out_data_o
);

  // configuration
  logic signed [ValW-1:0] tgt_pos_q;
  logic [GainW-1:0]       kp_ang_q, ki_ang_q, kd_ang_q, kp_pos_q, kd_pos_q;
  logic [LimW-1:0]        max_ang_q;
  logic [DtW-1:0]         dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_pos_q <= RstTargetPos;
      kp_ang_q  <= RstKpAngle;
      ki_ang_q  <= RstKiAngle;
      kd_ang_q  <= RstKdAngle;
      kp_pos_q  <= RstKpPos;
      kd_pos_q  <= RstKdPos;
      max_ang_q <= RstMaxAngle;
      dt_q      <= RstTimeStep;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_TARGET_POS: tgt_pos_q <= cfg_data_i[ValW-1:0];
        CFG_KP_ANGLE:   kp_ang_q  <= cfg_data_i[GainW-1:0];
        CFG_KI_ANGLE:   ki_ang_q  <= cfg_data_i[GainW-1:0];
        CFG_KD_ANGLE:   kd_ang_q  <= cfg_data_i[GainW-1:0];
        CFG_KP_POS:     kp_pos_q  <= cfg_data_i[GainW-1:0];
        CFG_KD_POS:     kd_pos_q  <= cfg_data_i[GainW-1:0];
        CFG_MAX_ANGLE:  max_ang_q <= cfg_data_i[LimW-1:0];
        CFG_TIME_STEP:  dt_q      <= cfg_data_i[DtW-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic signed [ValW-1:0] in_pos, in_vel, in_ang, in_rate, in_man;
  assign in_pos  = in_data_i[0*ValW +: ValW];
  assign in_vel  = in_data_i[1*ValW +: ValW];
  assign in_ang  = in_data_i[2*ValW +: ValW];
  assign in_rate = in_data_i[3*ValW +: ValW];
  assign in_man  = in_data_i[4*ValW +: ValW];

  logic signed [ValW-1:0] vel_q, ang_q, rate_q, man_q;
  logic signed [ValW-1:0] perr_q, a_q, aerr_q, p_q, i_q, d_q, sum_q;
  logic signed [TgtW-1:0] tgt_q;
  logic signed [ValW-1:0] integ_q;

  // shared multiplier
  logic signed [ValW-1:0]  mul_a;
  logic [GainW-1:0]        mul_b;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ValW-1:0]  prod_sat;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_POS_KP:  begin mul_a = perr_q;  mul_b = kp_pos_q; end
      MUL_VEL_KD:  begin mul_a = vel_q;   mul_b = kd_pos_q; end
      MUL_ERR_DT:  begin mul_a = aerr_q;  mul_b = GainW'(dt_q); end
      MUL_ERR_KP:  begin mul_a = aerr_q;  mul_b = kp_ang_q; end
      MUL_INT_KI:  begin mul_a = integ_q; mul_b = ki_ang_q; end
      MUL_RATE_KD: begin mul_a = rate_q;  mul_b = kd_ang_q; end
      default:     begin mul_a = perr_q;  mul_b = kp_pos_q; end
    endcase
  end

  assign prod_d   = ProdW'(mul_a) * ProdW'($signed({1'b0, mul_b}));
  assign prod_sat = mul_round(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // outer loop result, clamped to the configured angle limit
  logic signed [ValW-1:0] lim_s, tgt_raw, tgt_clamp;
  assign lim_s   = {{(ValW-LimW){1'b0}}, max_ang_q};
  assign tgt_raw = sat_sub(a_q, prod_sat);

  always_comb begin
    tgt_clamp = tgt_raw;
    if (tgt_raw > lim_s) begin
      tgt_clamp = lim_s;
    end else if (tgt_raw < -lim_s) begin
      tgt_clamp = -lim_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vel_q  <= in_vel;
      ang_q  <= in_ang;
      rate_q <= in_rate;
      man_q  <= in_man;
      perr_q <= sat_sub(tgt_pos_q, sat_add(in_pos, HalfCart));
    end
    if (cmd_i.wr_a) begin
      a_q <= prod_sat;
    end
    if (cmd_i.wr_tgt) begin
      tgt_q <= tgt_clamp[TgtW-1:0];
    end
    if (cmd_i.wr_aerr) begin
      aerr_q <= sat_sub(ang_q, ValW'(tgt_q));
    end
    if (cmd_i.wr_p) begin
      p_q <= prod_sat;
    end
    if (cmd_i.wr_i) begin
      i_q <= prod_sat;
    end
    if (cmd_i.wr_pd) begin
      d_q   <= prod_sat;
      sum_q <= sat_add(p_q, prod_sat);
    end
    if (cmd_i.wr_sum_i) begin
      sum_q <= sat_add(sum_q, i_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (cmd_i.wr_integ) begin
      integ_q <= sat_add(integ_q, prod_sat);
    end
  end

  // output register
  logic                out_valid_q;
  logic [OutW-1:0]     out_data_q;
  logic signed [ValW-1:0] force_d;

  assign force_d         = sat_add(sum_q, man_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {5'b0, d_q, i_q, p_q, aerr_q, tgt_q, perr_q, force_d};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.wr_integ |=> $stable(integ_q))
    else $error("error integral changed outside its update step");

  a_tgt_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_tgt |=> ((ValW'(tgt_q) <= lim_s) && (ValW'(tgt_q) >= -lim_s)))
    else $error("target angle outside clamp limit");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded word not presented");

endmodule

// ===== hdl/cascaded_balance_pid_core.sv =====
// Output: m_axis_tvalid is set when the finished tick is loaded into the output
//   register, which waits while the previous word is still waiting on m_axis_tready.
// Input: a new word is taken only once the previous tick is done, as six products go
//   one after another through the single shared 32x24 multiplier and the sum chain.
// Reset: rst_ni clears the sequencer, output valid and the error integral, and
//   returns all configuration registers to their default gains and limits.
// ----------------------------------------------------------------------------
// cascaded_balance_pid_core
// Cascaded PD (cart position) / PID (pole angle) balance controller, signed
// Q16.16, one control tick per input word.
// ----------------------------------------------------------------------------
module cascaded_balance_pid_core
  import cbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cart_position, cart_velocity, pole_angle, pole_rate, manual_force
  input  logic [InW-1:0]      s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // drive_force, position_error, target_angle, angle_error, p_term, i_term,
  // d_term, zero fill
  output logic [OutW-1:0]     m_axis_tdata
);

  cbp_cmd_t  cmd;
  cbp_stat_t stat;

  cbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cbp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
